// ----- design/vci_pkg.sv -----
// Shared types, codes and constants for the VOR course indicator.
// No dependencies; used by vci_cordic and vor_course_indicator.
package vci_pkg;

    localparam int STATIONS_DEF = 16;
    localparam int CORDIC_ITERS = 30;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_FIX   = 2'd2;

    localparam logic [1:0] TF_OFF  = 2'd0;
    localparam logic [1:0] TF_TO   = 2'd1;
    localparam logic [1:0] TF_FROM = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TUNED_FREQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBS_RADIAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd2;

    localparam logic [7:0]  FULL_SCALE_RST = 8'd10;
    localparam logic [31:0] Q_ONE          = 32'd1073741824;
    localparam logic [31:0] CORDIC_GAIN    = 32'd652032874;
    localparam logic [31:0] DIST_K         = 32'd691666;   // 2 * 345833
    localparam logic [31:0] DIST_MAX       = 32'd172920;
    localparam logic [14:0] DEFL_FULL      = 15'd16384;

    typedef struct packed {
        logic [1:0]          mode;
        logic signed [31:0]  lat;
        logic signed [31:0]  lon;
        logic [13:0]         freq;
    } vci_in_t;

    typedef struct packed {
        logic                valid_res;
        logic [1:0]          to_from;
        logic [15:0]         bearing;
        logic [17:0]         distance;
        logic signed [15:0]  deflection;
        logic [3:0]          station_index;
        logic                table_full;
    } vci_out_t;

    typedef struct packed {
        logic                start;
        logic                vec;      // 1: vectoring (atan2), 0: rotation (sin/cos)
        logic [31:0]         ang;
        logic signed [35:0]  x;
        logic signed [35:0]  y;
    } cordic_req_t;

    typedef struct packed {
        logic                done;
        logic signed [31:0]  sin;
        logic signed [31:0]  cos;
        logic [31:0]         ang;
    } cordic_rsp_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- design/vci_cordic.sv -----
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on vci_pkg (request/response types, arctangent table).
module vci_cordic (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vci_pkg::cordic_req_t req,
    output vci_pkg::cordic_rsp_t rsp
);
    import vci_pkg::*;

    localparam logic signed [33:0] Z_LIM   = 34'sd1073741824;
    localparam logic signed [35:0] Q36     = 36'sd1073741824;
    localparam logic [4:0]         LAST_IT = 5'(CORDIC_ITERS - 1);

    logic signed [35:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic [4:0]         it_reg;
    logic               busy_reg, done_reg, vec_reg, neg_reg, zero_reg;

    logic signed [33:0] z_init_a, z_init_b, atan_z;
    logic signed [35:0] x_sh, y_sh, x_out, y_out;
    logic               sigma;

    function automatic logic signed [31:0] clamp_q(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > Q36) begin
            r = 32'sd1073741824;
        end else if (v < -Q36) begin
            r = -32'sd1073741824;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_comb begin
        z_init_a = 34'(signed'(req.ang));
        z_init_b = 34'(signed'(req.ang + 32'h8000_0000));
        sigma    = vec_reg ? (y_reg <= 36'sd0) : (z_reg >= 34'sd0);
        x_sh     = x_reg >>> it_reg;
        y_sh     = y_reg >>> it_reg;
        atan_z   = signed'({2'b00, atan_entry(it_reg)});
        x_out    = neg_reg ? -x_reg : x_reg;
        y_out    = neg_reg ? -y_reg : y_reg;
    end

    assign rsp.done = done_reg;
    assign rsp.sin  = clamp_q(y_out);
    assign rsp.cos  = clamp_q(x_out);
    assign rsp.ang  = zero_reg ? 32'd0 : z_reg[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                it_reg   <= 5'd0;
                vec_reg  <= req.vec;
                if (req.vec) begin
                    neg_reg  <= 1'b0;
                    zero_reg <= (req.x == 36'sd0) && (req.y == 36'sd0);
                    if (req.x < 36'sd0) begin
                        x_reg <= -req.x;
                        y_reg <= -req.y;
                        z_reg <= 34'sh080000000;   // start at 180 degrees
                    end else begin
                        x_reg <= req.x;
                        y_reg <= req.y;
                        z_reg <= 34'sd0;
                    end
                end else begin
                    zero_reg <= 1'b0;
                    x_reg    <= 36'(signed'({1'b0, CORDIC_GAIN}));
                    y_reg    <= 36'sd0;
                    // fold angles beyond +-90 degrees, negate at the end
                    if (z_init_a > Z_LIM || z_init_a < -Z_LIM) begin
                        z_reg   <= z_init_b;
                        neg_reg <= 1'b1;
                    end else begin
                        z_reg   <= z_init_a;
                        neg_reg <= 1'b0;
                    end
                end
            end else if (busy_reg) begin
                if (sigma) begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - atan_z;
                end else begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + atan_z;
                end
                it_reg <= it_reg + 5'd1;
                if (it_reg == LAST_IT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- design/vor_course_indicator.sv -----
// VOR course indicator: station table, tuned-station search, bearing, distance, CDI.
// Add/clear/no-op items go from acceptance straight to ST_FIN. Fix items: a
// table search over the stored stations, then five sin/cos CORDIC runs and
// two atan2 runs on one shared CORDIC unit, and two 31-step square roots.
// One item in flight; the output register lets the next item in while a result waits.
// Reset (synchronous, aresetn low): table empty, registers 0 / 0 / 10; table contents undefined.
// Depends on vci_pkg and vci_cordic.
module vor_course_indicator #(
    parameter int STATIONS = vci_pkg::STATIONS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [vci_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vci_pkg::CFG_DATA_W-1:0] cfg_data,
    // input item channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  vci_pkg::vci_in_t               s_data,
    // result item channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output vci_pkg::vci_out_t              m_data
);
    import vci_pkg::*;

    localparam int IW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    localparam int CW = $clog2(STATIONS + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(STATIONS);

    // sequencer states
    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_RD        = 5'd1;   // table read issued
    localparam logic [4:0] ST_CHK       = 5'd2;   // frequency compare
    localparam logic [4:0] ST_CRD_GO    = 5'd3;   // launch sin/cos run
    localparam logic [4:0] ST_CRD_WAIT  = 5'd4;
    localparam logic [4:0] ST_MUL       = 5'd5;   // shared multiplier step
    localparam logic [4:0] ST_MUL_WB    = 5'd6;
    localparam logic [4:0] ST_BRG_GO    = 5'd7;   // bearing atan2
    localparam logic [4:0] ST_BRG_WAIT  = 5'd8;
    localparam logic [4:0] ST_SQ_RUN    = 5'd9;   // sqrt(a), then sqrt(1-a)
    localparam logic [4:0] ST_HALF_GO   = 5'd10;  // half central angle atan2
    localparam logic [4:0] ST_HALF_WAIT = 5'd11;
    localparam logic [4:0] ST_DMUL      = 5'd12;  // angle to distance scaling
    localparam logic [4:0] ST_DMUL_WB   = 5'd13;
    localparam logic [4:0] ST_DIV       = 5'd14;  // deflection divide
    localparam logic [4:0] ST_FIN       = 5'd15;  // hand result to output reg

    localparam logic [2:0] CRD_LAST = 3'd4;
    localparam logic [4:0] SQ_LAST  = 5'd30;
    localparam logic [4:0] DIV_LAST = 5'd21;

    // control
    logic [4:0]    state_reg;
    logic [CW-1:0] count_reg;
    logic [IW-1:0] idx_reg;
    logic [2:0]    crd_k_reg;
    logic [2:0]    mstep_reg;
    logic [4:0]    sq_cnt_reg;
    logic          sq_sel_reg;
    logic [4:0]    dv_cnt_reg;
    logic          m_valid_reg;

    // configuration
    logic [13:0] tuned_reg;
    logic [15:0] obs_reg;
    logic [7:0]  fs_reg;

    // station table
    logic [31:0] mem_lat  [STATIONS];
    logic [31:0] mem_lon  [STATIONS];
    logic [13:0] mem_freq [STATIONS];
    logic [31:0] rd_lat, rd_lon;
    logic [13:0] rd_freq;

    // datapath
    logic [31:0]        lat_reg, lon_reg;
    logic signed [31:0] s1_reg, c1_reg, s2_reg, c2_reg, sd_reg, cd_reg, sl_reg, sn_reg;
    logic signed [31:0] yb_reg, p1_reg, t_reg, p4_reg;
    logic signed [32:0] xb_reg;
    logic [30:0]        a_reg;
    logic signed [63:0] prod_reg;
    logic [31:0]        brg_reg;
    logic [61:0]        sq_v_reg, sq_r_reg, sq_b_reg;
    logic [30:0]        ra_reg;
    logic [30:0]        half_reg;
    logic [17:0]        dist_reg;
    logic [21:0]        dv_q_reg;
    logic [7:0]         dv_rem_reg;
    vci_out_t           res_reg, out_reg;

    cordic_req_t creq;
    cordic_rsp_t crsp;

    logic               s_acc, match;
    logic signed [14:0] df;
    logic [31:0]        dlat, dlon, crd_ang;
    logic signed [31:0] mul_a, mul_b, q_val;
    logic signed [33:0] a_sum;
    logic [61:0]        sq_sum, sq_r_n;
    logic               sq_ge;
    logic [31:0]        obs32, rdiff, bdiff;
    logic [32:0]        rmag, bmag;
    logic [40:0]        prod180;
    logic [7:0]         fs_eff;
    logic [8:0]         dv_sh, fs9;
    logic               dv_ge;
    logic [7:0]         dv_rem_n;
    logic [21:0]        dv_q_n;
    logic [14:0]        defl_mag;
    logic [63:0]        d_round;
    logic [31:0]        d_raw;

    vci_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .rsp     (crsp)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // station match: |freq - tuned| < 5
    assign df    = signed'({1'b0, rd_freq}) - signed'({1'b0, tuned_reg});
    assign match = (df > -15'sd5) && (df < 15'sd5);

    // CORDIC launch: the five angles, then the two atan2 runs
    always_comb begin
        dlat = rd_lat - lat_reg;
        dlon = rd_lon - lon_reg;
        unique case (crd_k_reg)
            3'd0:    crd_ang = lat_reg;
            3'd1:    crd_ang = rd_lat;
            3'd2:    crd_ang = dlon;
            3'd3:    crd_ang = {dlat[31], dlat[31:1]};
            default: crd_ang = {dlon[31], dlon[31:1]};
        endcase
        creq.start = (state_reg == ST_CRD_GO) || (state_reg == ST_BRG_GO)
                     || (state_reg == ST_HALF_GO);
        creq.vec   = (state_reg != ST_CRD_GO);
        creq.ang   = crd_ang;
        if (state_reg == ST_HALF_GO) begin
            creq.x = 36'(signed'({1'b0, sq_r_reg[30:0]}));
            creq.y = 36'(signed'({1'b0, ra_reg}));
        end else begin
            creq.x = 36'(xb_reg);
            creq.y = 36'(yb_reg);
        end
    end

    // shared multiplier operand select
    always_comb begin
        if (state_reg == ST_DMUL) begin
            mul_a = signed'({1'b0, half_reg});
            mul_b = signed'(DIST_K);
        end else begin
            unique case (mstep_reg)
                3'd0:    begin mul_a = sd_reg; mul_b = c2_reg; end
                3'd1:    begin mul_a = c1_reg; mul_b = s2_reg; end
                3'd2:    begin mul_a = s1_reg; mul_b = c2_reg; end
                3'd3:    begin mul_a = t_reg;  mul_b = cd_reg; end
                3'd4:    begin mul_a = sl_reg; mul_b = sl_reg; end
                3'd5:    begin mul_a = c1_reg; mul_b = c2_reg; end
                default: begin mul_a = t_reg;  mul_b = sn_reg; end
            endcase
        end
        q_val = prod_reg[61:30];
        a_sum = 34'(p4_reg) + 34'(q_val);
    end

    // restoring square root, two radicand bits per step
    always_comb begin
        sq_sum = sq_r_reg + sq_b_reg;
        sq_ge  = (sq_v_reg >= sq_sum);
        sq_r_n = sq_ge ? ((sq_r_reg >> 1) + sq_b_reg) : (sq_r_reg >> 1);
    end

    // radial error, TO/FROM, deflection divide
    always_comb begin
        obs32    = {obs_reg, 16'h0000};
        rdiff    = obs32 - brg_reg - 32'h8000_0000;
        bdiff    = brg_reg - obs32;
        rmag     = rdiff[31] ? (33'({1'b0, ~rdiff}) + 33'd1) : {1'b0, rdiff};
        bmag     = bdiff[31] ? (33'({1'b0, ~bdiff}) + 33'd1) : {1'b0, bdiff};
        prod180  = 41'(rmag) * 41'd180;
        fs_eff   = (fs_reg == 8'd0) ? 8'd1 : fs_reg;
        fs9      = {1'b0, fs_eff};
        dv_sh    = {dv_rem_reg, dv_q_reg[21]};
        dv_ge    = (dv_sh >= fs9);
        dv_rem_n = dv_ge ? 8'(dv_sh - fs9) : dv_sh[7:0];
        dv_q_n   = {dv_q_reg[20:0], dv_ge};
        defl_mag = (dv_q_n > 22'(DEFL_FULL)) ? DEFL_FULL : dv_q_n[14:0];
        d_round  = 64'(prod_reg) + 64'h8000_0000;
        d_raw    = d_round[63:32];
    end

    // station table: one write port, registered read
    always_ff @(posedge aclk) begin
        if (s_acc && (s_data.mode == MODE_ADD) && (count_reg < CNT_FULL)) begin
            mem_lat[count_reg[IW-1:0]]  <= s_data.lat;
            mem_lon[count_reg[IW-1:0]]  <= s_data.lon;
            mem_freq[count_reg[IW-1:0]] <= s_data.freq;
        end
        if (state_reg == ST_RD) begin
            rd_lat  <= mem_lat[idx_reg];
            rd_lon  <= mem_lon[idx_reg];
            rd_freq <= mem_freq[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            tuned_reg   <= 14'd0;
            obs_reg     <= 16'd0;
            fs_reg      <= FULL_SCALE_RST;
        end else begin
            prod_reg <= mul_a * mul_b;

            if (cfg_we) begin
                unique case (cfg_index)
                    REG_TUNED_FREQ: tuned_reg <= cfg_data[13:0];
                    REG_OBS_RADIAL: obs_reg   <= cfg_data;
                    REG_FULL_SCALE: fs_reg    <= cfg_data[7:0];
                    default: ;
                endcase
            end

            // output register drains; ST_FIN refills it on its own
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        lat_reg   <= s_data.lat;
                        lon_reg   <= s_data.lon;
                        res_reg   <= '0;
                        idx_reg   <= '0;
                        state_reg <= ST_FIN;
                        unique case (s_data.mode)
                            MODE_ADD: begin
                                if (count_reg < CNT_FULL) begin
                                    res_reg.station_index <= 4'(count_reg);
                                    count_reg <= count_reg + 1'b1;
                                end else begin
                                    res_reg.table_full <= 1'b1;
                                end
                            end
                            MODE_CLEAR: count_reg <= '0;
                            MODE_FIX: begin
                                if (count_reg != '0) begin
                                    state_reg <= ST_RD;
                                end
                            end
                            default: ;   // reserved mode: all-zero result
                        endcase
                    end
                end
                ST_RD: state_reg <= ST_CHK;
                ST_CHK: begin
                    if (match) begin
                        crd_k_reg <= 3'd0;
                        state_reg <= ST_CRD_GO;
                    end else if (CW'(idx_reg) + 1'b1 == count_reg) begin
                        state_reg <= ST_FIN;   // no station on this frequency
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_CRD_GO: state_reg <= ST_CRD_WAIT;
                ST_CRD_WAIT: begin
                    if (crsp.done) begin
                        unique case (crd_k_reg)
                            3'd0:    begin s1_reg <= crsp.sin; c1_reg <= crsp.cos; end
                            3'd1:    begin s2_reg <= crsp.sin; c2_reg <= crsp.cos; end
                            3'd2:    begin sd_reg <= crsp.sin; cd_reg <= crsp.cos; end
                            3'd3:    sl_reg <= crsp.sin;
                            default: sn_reg <= crsp.sin;
                        endcase
                        crd_k_reg <= crd_k_reg + 3'd1;
                        if (crd_k_reg == CRD_LAST) begin
                            mstep_reg <= 3'd0;
                            state_reg <= ST_MUL;
                        end else begin
                            state_reg <= ST_CRD_GO;
                        end
                    end
                end
                ST_MUL: state_reg <= ST_MUL_WB;
                ST_MUL_WB: begin
                    // bearing: y = sd*c2, x = c1*s2 - s1*c2*cd
                    // haversine: a = sl^2 + c1*c2*sn^2
                    unique case (mstep_reg)
                        3'd0: yb_reg <= q_val;
                        3'd1: p1_reg <= q_val;
                        3'd3: xb_reg <= 33'(p1_reg) - 33'(q_val);
                        3'd4: p4_reg <= q_val;
                        3'd7: begin
                            if (a_sum < 34'sd0) begin
                                a_reg <= 31'd0;
                            end else if (a_sum > 34'(Q_ONE)) begin
                                a_reg <= Q_ONE[30:0];
                            end else begin
                                a_reg <= a_sum[30:0];
                            end
                        end
                        default: t_reg <= q_val;
                    endcase
                    mstep_reg <= mstep_reg + 3'd1;
                    state_reg <= (mstep_reg == 3'd7) ? ST_BRG_GO : ST_MUL;
                end
                ST_BRG_GO: state_reg <= ST_BRG_WAIT;
                ST_BRG_WAIT: begin
                    if (crsp.done) begin
                        brg_reg    <= crsp.ang;
                        sq_v_reg   <= {1'b0, a_reg, 30'd0};
                        sq_r_reg   <= '0;
                        sq_b_reg   <= 62'd1 << 60;
                        sq_cnt_reg <= 5'd0;
                        sq_sel_reg <= 1'b0;
                        state_reg  <= ST_SQ_RUN;
                    end
                end
                ST_SQ_RUN: begin
                    if (sq_ge) begin
                        sq_v_reg <= sq_v_reg - sq_sum;
                    end
                    sq_r_reg   <= sq_r_n;
                    sq_b_reg   <= sq_b_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg + 5'd1;
                    if (sq_cnt_reg == SQ_LAST) begin
                        if (!sq_sel_reg) begin
                            ra_reg     <= sq_r_n[30:0];
                            sq_v_reg   <= {1'b0, Q_ONE[30:0] - a_reg, 30'd0};
                            sq_r_reg   <= '0;
                            sq_b_reg   <= 62'd1 << 60;
                            sq_cnt_reg <= 5'd0;
                            sq_sel_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_HALF_GO;
                        end
                    end
                end
                ST_HALF_GO: begin
                    sq_r_reg  <= sq_r_reg;   // rb held for the launch
                    state_reg <= ST_HALF_WAIT;
                end
                ST_HALF_WAIT: begin
                    if (crsp.done) begin
                        if (crsp.ang[31]) begin
                            half_reg <= 31'd0;
                        end else if (crsp.ang > Q_ONE) begin
                            half_reg <= Q_ONE[30:0];
                        end else begin
                            half_reg <= crsp.ang[30:0];
                        end
                        state_reg <= ST_DMUL;
                    end
                end
                ST_DMUL: state_reg <= ST_DMUL_WB;
                ST_DMUL_WB: begin
                    dist_reg   <= (d_raw > DIST_MAX) ? DIST_MAX[17:0] : d_raw[17:0];
                    dv_q_reg   <= prod180[38:17];
                    dv_rem_reg <= 8'd0;
                    dv_cnt_reg <= 5'd0;
                    state_reg  <= ST_DIV;
                end
                ST_DIV: begin
                    dv_q_reg   <= dv_q_n;
                    dv_rem_reg <= dv_rem_n;
                    dv_cnt_reg <= dv_cnt_reg + 5'd1;
                    if (dv_cnt_reg == DIV_LAST) begin
                        res_reg.valid_res     <= 1'b1;
                        res_reg.to_from       <= (bmag <= 33'(Q_ONE)) ? TF_TO : TF_FROM;
                        res_reg.bearing       <= 16'(brg_reg[31:16] + 16'(brg_reg[15]));
                        res_reg.distance      <= dist_reg;
                        res_reg.deflection    <= rdiff[31] ? signed'(16'd0 - {1'b0, defl_mag})
                                                           : signed'({1'b0, defl_mag});
                        res_reg.station_index <= 4'(idx_reg);
                        res_reg.table_full    <= 1'b0;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg     <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for vor_course_indicator: station table, bearing, distance, CDI.
// Depends on vci_pkg; holds its own bit-exact predictor of the block.

module testbench;
    import vci_pkg::*;

    localparam logic [1:0] MODE_NONE   = 2'd3;   // unused code, block gives an all-zero result
    localparam longint     QONE        = 64'sd1073741824;
    localparam longint     GAIN        = 64'sd652032874;
    localparam longint     NM16_PER_BA = 64'sd345833;
    localparam longint     NM16_MAX    = 64'sd172920;
    localparam int         N_ITEMS     = 2000;
    localparam longint     CYCLE_LIMIT = 64'd6000000;

    // ------------------------------------------------------------------
    // Scoreboard: predicts each result and checks the block against it
    // ------------------------------------------------------------------
    class nav_scoreboard;
        logic [31:0] atan_ba [30];
        logic [31:0] stn_lat [STATIONS_DEF];
        logic [31:0] stn_lon [STATIONS_DEF];
        logic [13:0] stn_freq[STATIONS_DEF];
        int          stn_count;
        logic [13:0] tuned;
        logic [15:0] radial;
        logic [7:0]  full_scale;
        vci_out_t    expected_q[$];
        int          mismatches;
        int          n_fix_hits, n_fix_miss, n_adds, n_full, n_checked;

        function new();
            atan_ba = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
                        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
                        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
                        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
                        32'h00000002, 32'h00000001};
            stn_count  = 0;
            tuned      = '0;
            radial     = '0;
            full_scale = FULL_SCALE_RST;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TUNED_FREQ: tuned      = val[13:0];
                REG_OBS_RADIAL: radial     = val[15:0];
                REG_FULL_SCALE: full_scale = val[7:0];
                default: ;
            endcase
        endfunction

        function longint sx(logic [31:0] a);
            return longint'($signed(a));
        endfunction

        function longint qmul(longint a, longint b);
            return (a * b) >>> 30;
        endfunction

        function longint clampq(longint v);
            if (v > QONE) return QONE;
            if (v < -QONE) return -QONE;
            return v;
        endfunction

        // rotation-mode CORDIC; folds angles beyond +-90 deg by a half turn
        function void sin_cos(logic [31:0] ang, output longint s, output longint c);
            longint z, x, y, nx, ny;
            bit flip;
            z = sx(ang); x = GAIN; y = 0; flip = 0;
            if (z > QONE || z < -QONE) begin
                z = sx(ang + 32'h80000000);
                flip = 1;
            end
            for (int i = 0; i < 30; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(atan_ba[i]);
                end else begin
                    nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(atan_ba[i]);
                end
                x = nx; y = ny;
            end
            if (flip) begin
                x = -x; y = -y;
            end
            s = clampq(y);
            c = clampq(x);
        endfunction

        function logic [31:0] atan2_ba(longint y, longint x);
            logic [31:0] z;
            longint nx, ny;
            z = '0;
            if (x == 0 && y == 0) return '0;
            if (x < 0) begin
                x = -x; y = -y; z = 32'h80000000;
            end
            for (int i = 0; i < 30; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i); ny = y - (x >>> i); z += atan_ba[i];
                end else begin
                    nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_ba[i];
                end
                x = nx; y = ny;
            end
            return z;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b; r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function logic [31:0] course_to(logic [31:0] la1, lo1, la2, lo2);
            longint s1, c1, s2, c2, sd, cd;
            sin_cos(la1, s1, c1);
            sin_cos(la2, s2, c2);
            sin_cos(lo2 - lo1, sd, cd);
            return atan2_ba(qmul(sd, c2), qmul(c1, s2) - qmul(qmul(s1, c2), cd));
        endfunction

        // haversine range in 1/16 NM
        function logic [17:0] range_to(logic [31:0] la1, lo1, la2, lo2);
            longint s1, c1, s2, c2, sl, cl, sn, cn, hav;
            longint unsigned ra, rb, d;
            logic [31:0] dlat_h, dlon_h, half;
            sin_cos(la1, s1, c1);
            sin_cos(la2, s2, c2);
            dlat_h = 32'(sx(la2 - la1) >>> 1);
            dlon_h = 32'(sx(lo2 - lo1) >>> 1);
            sin_cos(dlat_h, sl, cl);
            sin_cos(dlon_h, sn, cn);
            hav = qmul(sl, sl) + qmul(qmul(qmul(c1, c2), sn), sn);
            if (hav < 0) hav = 0;
            if (hav > QONE) hav = QONE;
            ra = int_sqrt(longint'(hav) << 30);
            rb = int_sqrt(longint'(QONE - hav) << 30);
            half = atan2_ba(longint'(ra), longint'(rb));
            if (half >= 32'h80000000) half = '0;
            if (half > 32'h40000000) half = 32'h40000000;
            d = ((longint'(half) * 2) * NM16_PER_BA + 64'h80000000) >> 32;
            if (d > NM16_MAX) d = NM16_MAX;
            return d[17:0];
        endfunction

        function void note_item(vci_in_t it);
            vci_out_t r;
            int hit;
            longint df, rdiff, bdiff, fs, defl;
            logic [31:0] brg, obs;
            r = '0;
            case (it.mode)
                MODE_ADD: begin
                    if (stn_count < STATIONS_DEF) begin
                        stn_lat[stn_count]  = it.lat;
                        stn_lon[stn_count]  = it.lon;
                        stn_freq[stn_count] = it.freq;
                        r.station_index     = 4'(stn_count);
                        stn_count++;
                        n_adds++;
                    end else begin
                        r.table_full = 1'b1;
                        n_full++;
                    end
                end
                MODE_CLEAR: stn_count = 0;
                MODE_FIX: begin
                    hit = -1;
                    for (int i = 0; i < stn_count && hit < 0; i++) begin
                        df = longint'(stn_freq[i]) - longint'(tuned);
                        if (df > -5 && df < 5) hit = i;
                    end
                    if (hit >= 0) begin
                        brg   = course_to(it.lat, it.lon, stn_lat[hit], stn_lon[hit]);
                        obs   = {radial, 16'h0000};
                        rdiff = sx(obs - (brg + 32'h80000000));
                        bdiff = sx(brg - obs);
                        fs    = (full_scale != 0) ? longint'(full_scale) : 1;
                        defl  = (rdiff * 180) / (fs * 131072);
                        if (defl > 16384) defl = 16384;
                        if (defl < -16384) defl = -16384;
                        if (bdiff < 0) bdiff = -bdiff;
                        r.valid_res     = 1'b1;
                        r.to_from       = (bdiff <= QONE) ? TF_TO : TF_FROM;
                        r.bearing       = 16'((brg + 32'h8000) >> 16);
                        r.distance      = range_to(it.lat, it.lon, stn_lat[hit], stn_lon[hit]);
                        r.deflection    = 16'(defl);
                        r.station_index = 4'(hit);
                        n_fix_hits++;
                    end else begin
                        n_fix_miss++;
                    end
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(vci_out_t got);
            vci_out_t e;
            string bad;
            n_checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result item %p", got);
                return;
            end
            e = expected_q.pop_front();
            bad = "";
            if (got.valid_res !== e.valid_res)         bad = {bad, " valid_res"};
            if (got.to_from !== e.to_from)             bad = {bad, " to_from"};
            if (got.bearing !== e.bearing)             bad = {bad, " bearing"};
            if (got.distance !== e.distance)           bad = {bad, " distance"};
            if (got.deflection !== e.deflection)       bad = {bad, " deflection"};
            if (got.station_index !== e.station_index) bad = {bad, " station_index"};
            if (got.table_full !== e.table_full)       bad = {bad, " table_full"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result %0d field(s)%s differ", n_checked, bad);
                    $display("  exp %p", e);
                    $display("  got %p", got);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    vci_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    vci_out_t              m_data;

    nav_scoreboard sb = new();
    int     tx_idle_pct = 0;       // sender idle chance, percent
    int     rx_idle_pct = 0;       // receiver stall chance, percent
    int     hold_left   = 0;       // long receiver hold-off, cycles remaining
    longint cycles      = 0;
    int     n_sent      = 0;
    int     n_cfg       = 0;

    vor_course_indicator i_dut (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.expected_q.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    // The check uses m_ready as sampled at this edge, before it is updated.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks. Each is entered and left just after a rising edge.
    // ------------------------------------------------------------------

    // Offers one item; valid is only lowered on an idle cycle, so back-to-back
    // items never see two assignments to s_valid in one step.
    task automatic send_item(vci_in_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(it);
        if (it.mode != MODE_NONE) n_sent++;
    endtask

    // Let every expected result come out; add/clear go straight to the result stage
    // and every item yields a result, so a short margin is enough.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Writes all three registers in consecutive cycles; block must be idle.
    task automatic set_regs(logic [13:0] tf, logic [15:0] obs, logic [7:0] fs);
        logic [CFG_DATA_W-1:0] vals[3];
        logic [CFG_IDX_W-1:0]  idxs[3];
        vals = '{CFG_DATA_W'(tf), obs, CFG_DATA_W'(fs)};
        idxs = '{REG_TUNED_FREQ, REG_OBS_RADIAL, REG_FULL_SCALE};
        for (int i = 0; i < 3; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            sb.write_reg(idxs[i], vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        n_cfg++;
    endtask

    function automatic vci_in_t mk(logic [1:0] m, logic [31:0] la, logic [31:0] lo,
                                   logic [13:0] f);
        vci_in_t it;
        it.mode = m; it.lat = la; it.lon = lo; it.freq = f;
        return it;
    endfunction

    // latitude: mostly in range, sometimes any 32-bit value
    function automatic logic [31:0] rand_lat();
        if ($urandom_range(9) == 0) return $urandom;
        return 32'($signed($urandom_range(32'h80000000)) - 32'sh40000000);
    endfunction

    // station frequency: often within a few units of the tuned one
    function automatic logic [13:0] rand_freq();
        if ($urandom_range(9) < 6) return sb.tuned + 14'($urandom_range(12)) - 14'd6;
        return 14'($urandom_range(16383));
    endfunction

    task automatic random_config();
        logic [13:0] tf;
        logic [15:0] obs;
        logic [7:0]  fs;
        case ($urandom_range(3))
            0: tf = '0;
            1: tf = 14'h3FFF;
            default: tf = 14'($urandom_range(16383));
        endcase
        case ($urandom_range(3))
            0: obs = '0;
            1: obs = 16'hFFFF;
            default: obs = 16'($urandom_range(65535));
        endcase
        case ($urandom_range(5))
            0: fs = 8'd1;
            1: fs = 8'd180;
            2: fs = 8'd0;                // treated as 1
            default: fs = 8'($urandom_range(180, 1));
        endcase
        set_regs(tf, obs, fs);
    endtask

    // One well-formed burst: maybe clear, fill some stations, then fixes.
    // About one burst in ten is noise instead.
    task automatic random_burst();
        int nadd, nfix, k;
        logic [31:0] la, lo;
        if ($urandom_range(9) == 0) begin
            send_item(mk(2'($urandom_range(3)), $urandom, $urandom,
                         14'($urandom_range(16383))));
            return;
        end
        if ($urandom_range(2) == 0)
            send_item(mk(MODE_CLEAR, $urandom, $urandom, 14'($urandom)));
        nadd = $urandom_range(4) == 0 ? $urandom_range(18, 10) : $urandom_range(4);
        for (int i = 0; i < nadd; i++)
            send_item(mk(MODE_ADD, rand_lat(), $urandom, rand_freq()));
        nfix = $urandom_range(5, 1);
        for (int i = 0; i < nfix; i++) begin
            k = sb.stn_count > 0 ? $urandom_range(sb.stn_count - 1) : 0;
            case ($urandom_range(3))
                0: begin                                   // right on a station
                    la = sb.stn_lat[k]; lo = sb.stn_lon[k];
                end
                1: begin                                   // close to a station
                    la = sb.stn_lat[k] + 32'($signed($urandom_range(2000000)) - 1000000);
                    lo = sb.stn_lon[k] + 32'($signed($urandom_range(2000000)) - 1000000);
                end
                default: begin
                    la = rand_lat(); lo = $urandom;
                end
            endcase
            if (sb.stn_count == 0) begin
                la = rand_lat(); lo = $urandom;
            end
            send_item(mk(MODE_FIX, la, lo, 14'($urandom_range(16383))));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase_tx[3], phase_rx[3];
        phase_tx = '{33, 78, 0};
        phase_rx = '{78, 33, 0};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: table edges, every mode, coincident points, no match
        set_regs(14'd100, 16'h0000, 8'd10);
        send_item(mk(MODE_FIX, 32'h0, 32'h0, 14'd0));             // empty table
        send_item(mk(MODE_ADD, 32'h40000000, 32'h80000000, 14'd104));
        send_item(mk(MODE_ADD, 32'hC0000000, 32'h7FFFFFFF, 14'h3FFF));
        send_item(mk(MODE_ADD, 32'h0, 32'h0, 14'd96));
        send_item(mk(MODE_FIX, 32'h0, 32'h0, 14'h3FFF));           // picks first match
        send_item(mk(MODE_FIX, 32'h40000000, 32'h80000000, 14'd0)); // same point
        send_item(mk(MODE_FIX, 32'h7FFFFFFF, 32'h12345678, 14'd0)); // latitude out of range
        send_item(mk(MODE_FIX, 32'h80000000, 32'hFFFFFFFF, 14'd0));
        send_item(mk(MODE_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 14'h3FFF));
        for (int i = 0; i < 14; i++)                               // fill, then overflow
            send_item(mk(MODE_ADD, 32'(i) << 26, 32'(i) << 28, 14'(200 + i)));
        send_item(mk(MODE_CLEAR, 32'h0, 32'h0, 14'd0));
        send_item(mk(MODE_FIX, 32'h01000000, 32'h01000000, 14'd0)); // cleared, no match
        drain();
        set_regs(14'h3FFF, 16'hFFFF, 8'd180);
        send_item(mk(MODE_ADD, 32'h00100000, 32'hFFF00000, 14'h3FFB));
        send_item(mk(MODE_FIX, 32'hFFF00000, 32'h00100000, 14'd0));
        drain();
        set_regs(14'd0, 16'h4000, 8'd0);                          // full scale zero
        send_item(mk(MODE_ADD, 32'h20000000, 32'h20000000, 14'd4));
        send_item(mk(MODE_FIX, 32'hE0000000, 32'hE0000000, 14'd0));

        // random part in three idle phases, new register values every so often
        for (int p = 0; p < 3; p++) begin
            drain();
            tx_idle_pct = phase_tx[p];
            rx_idle_pct = phase_rx[p];
            random_config();
            if (p == 0) hold_left <= 3000;   // long stall: block fills and stops taking items
            while (n_sent < 25 + (p + 1) * N_ITEMS / 3) begin
                random_burst();
                if ($urandom_range(29) == 0) begin
                    drain();
                    random_config();
                end
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);

        $display("ran %0d items over %0d register settings: %0d fixes matched, %0d unmatched,",
                 n_sent, n_cfg, sb.n_fix_hits, sb.n_fix_miss);
        $display("%0d stations stored, %0d adds refused on a full table, %0d mismatches",
                 sb.n_adds, sb.n_full, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
